// ----- hdl/pbd_pkg.sv -----
// Package for the polar bin descriptor: payload structs, bin record type,
// fixed constants and the CORDIC arctangent table.
// No dependencies.
`default_nettype none
package pbd_pkg;

  localparam int NUM_SECTORS_DEF = 60;
  localparam int NUM_RINGS_DEF   = 20;
  localparam int CORDIC_STEPS    = 20;
  localparam int XW              = 36;   // CORDIC x/y datapath width
  localparam int ACCW            = 34;   // angle accumulator width
  localparam logic [31:0] RING_SCALE_RST = 32'h0100_0000;
  localparam logic [29:0] GAIN_INV_Q30   = 30'd652032874;

  // item kinds
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [23:0] coord_height;
    logic signed [23:0] coord_lateral;
    logic signed [23:0] coord_depth;
    logic [15:0]        point_intensity;
    logic [10:0]        bin_index;
  } item_t;

  typedef struct packed {
    logic [23:0] height_range;
    logic        intensity_bit;
    logic        occupied;
  } result_t;

  typedef struct packed {
    logic [15:0]        count;
    logic signed [23:0] low;
    logic signed [23:0] high;
    logic [31:0]        sum;
  } bin_rec_t;

  // atan(2^-i) as a binary angle, full turn = 2^32
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h2000_0000;
      5'd1:  r = 32'h12E4_051E;
      5'd2:  r = 32'h09FB_385B;
      5'd3:  r = 32'h0511_11D4;
      5'd4:  r = 32'h028B_0D43;
      5'd5:  r = 32'h0145_D7E1;
      5'd6:  r = 32'h00A2_F61E;
      5'd7:  r = 32'h0051_7C55;
      5'd8:  r = 32'h0028_BE53;
      5'd9:  r = 32'h0014_5F2F;
      5'd10: r = 32'h000A_2F98;
      5'd11: r = 32'h0005_17CC;
      5'd12: r = 32'h0002_8BE6;
      5'd13: r = 32'h0001_45F3;
      5'd14: r = 32'h0000_A2FA;
      5'd15: r = 32'h0000_517D;
      5'd16: r = 32'h0000_28BE;
      5'd17: r = 32'h0000_145F;
      5'd18: r = 32'h0000_0A30;
      5'd19: r = 32'h0000_0518;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/polar_bin_descriptor_core.sv -----
// Polar bin descriptor core: CORDIC binning of points, per-bin store, reads and clears.
// Depends on pbd_pkg and pbd_ram.
//
// Channel   Direction  Transfer
// item      in         start high and busy low at a rising edge
// result    out        done high for one cycle, no back pressure
// config    in         ring_scale_we high at a rising edge
//
// Add point: 20 CORDIC steps, three passes through the shared 32x32
// multiplier, a bin read and write if the ring is in range. Read bin: a
// bin read and a mean comparison; no store access when the index is past
// the store. Clear: one RAM row a cycle over NUM_SECTORS*NUM_RINGS rows.
// The same clearing pass runs after reset, busy high. Results cannot be stalled.
`default_nettype none
module polar_bin_descriptor_core #(
  parameter int NUM_SECTORS = pbd_pkg::NUM_SECTORS_DEF,
  parameter int NUM_RINGS   = pbd_pkg::NUM_RINGS_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    start,
  output logic                   busy,
  input  pbd_pkg::item_t         item,
  output logic                   done,
  output pbd_pkg::result_t       result,
  input  wire                    ring_scale_we,
  input  wire [31:0]             ring_scale_wdata
);

  localparam int NUM_BINS = NUM_SECTORS * NUM_RINGS;
  localparam int AW       = $clog2(NUM_BINS);
  localparam int SW       = $clog2(NUM_SECTORS);
  localparam int XW       = pbd_pkg::XW;
  localparam int ACCW     = pbd_pkg::ACCW;
  localparam int RECW     = $bits(pbd_pkg::bin_rec_t);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLEAR = 4'd1;
  localparam logic [3:0] ST_ROT   = 4'd2;
  localparam logic [3:0] ST_RAD   = 4'd3;
  localparam logic [3:0] ST_RADF  = 4'd4;
  localparam logic [3:0] ST_SEC   = 4'd5;
  localparam logic [3:0] ST_RING  = 4'd6;
  localparam logic [3:0] ST_IDX   = 4'd7;
  localparam logic [3:0] ST_RD    = 4'd8;
  localparam logic [3:0] ST_UPD   = 4'd9;
  localparam logic [3:0] ST_RLAT  = 4'd10;
  localparam logic [3:0] ST_RM2   = 4'd11;
  localparam logic [3:0] ST_RM3   = 4'd12;
  localparam logic [3:0] ST_CMP   = 4'd13;

  localparam logic signed [ACCW-1:0] ACC_QTR = ACCW'(34'sh0_4000_0000);

  logic [3:0]             state;
  logic [31:0]            ring_scale;
  logic [47:0]            total_intensity;
  logic [31:0]            total_points;
  logic                   is_add;
  logic signed [23:0]     height;
  logic [15:0]            inten;
  logic signed [XW-1:0]   x;
  logic signed [XW-1:0]   y;
  logic signed [ACCW-1:0] acc;
  logic [4:0]             iter;
  logic [31:0]            radius;
  logic [SW-1:0]          sector;
  logic [AW-1:0]          addr;
  logic [63:0]            prod;
  logic [63:0]            lhs;
  logic [63:0]            rhs_lo;
  pbd_pkg::bin_rec_t      rec;

  logic [31:0]            mul_a;
  logic [31:0]            mul_b;
  logic                   ram_we;
  pbd_pkg::bin_rec_t      ram_wdata;
  logic [RECW-1:0]        ram_rdata_raw;
  pbd_pkg::bin_rec_t      ram_rdata;

  // prerotation inputs
  logic signed [XW-1:0]   x_in;
  logic signed [XW-1:0]   y_in;
  logic signed [XW-1:0]   dx;
  logic signed [XW-1:0]   dy;
  logic [63:0]            rad_sum;

  assign busy      = (state != ST_IDLE);
  assign ram_rdata = pbd_pkg::bin_rec_t'(ram_rdata_raw);

  assign x_in = {{(XW-32){item.coord_lateral[23]}}, item.coord_lateral, 8'b0};
  assign y_in = {{(XW-32){item.coord_depth[23]}}, item.coord_depth, 8'b0};
  assign dx   = y >>> iter;
  assign dy   = x >>> iter;
  assign rad_sum = prod + (x[32] ? {2'b00, pbd_pkg::GAIN_INV_Q30, 32'b0} : 64'd0);

  // bin store
  pbd_ram #(
    .WIDTH (RECW),
    .DEPTH (NUM_BINS)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (addr),
    .wr_data (ram_wdata),
    .rd_addr (addr),
    .rd_data (ram_rdata_raw)
  );

  // shared multiplier operand select
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      ST_RAD: begin
        mul_a = x[31:0];
        mul_b = {2'b00, pbd_pkg::GAIN_INV_Q30};
      end
      ST_SEC: begin
        mul_a = {~acc[31], acc[30:0]};
        mul_b = 32'(NUM_SECTORS);
      end
      ST_RING: begin
        mul_a = radius;
        mul_b = ring_scale;
      end
      ST_RLAT: begin
        mul_a = ram_rdata.sum;
        mul_b = total_points;
      end
      ST_RM2: begin
        mul_a = total_intensity[31:0];
        mul_b = {16'd0, rec.count};
      end
      ST_RM3: begin
        mul_a = {16'd0, total_intensity[47:32]};
        mul_b = {16'd0, rec.count};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // bin write: zero row on clear, merged record on update unless count is full
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = ram_rdata;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      ST_UPD: begin
        if (ram_rdata.count == 16'd0) begin
          ram_we          = 1'b1;
          ram_wdata.count = 16'd1;
          ram_wdata.low   = height;
          ram_wdata.high  = height;
          ram_wdata.sum   = {16'd0, inten};
        end else if (ram_rdata.count != 16'hFFFF) begin
          ram_we          = 1'b1;
          ram_wdata.count = ram_rdata.count + 16'd1;
          ram_wdata.sum   = ram_rdata.sum + {16'd0, inten};
          if (height < ram_rdata.low) begin
            ram_wdata.low = height;
          end
          if (height > ram_rdata.high) begin
            ram_wdata.high = height;
          end
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= {32'd0, mul_a} * {32'd0, mul_b};
  end

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_scale <= pbd_pkg::RING_SCALE_RST;
    end else if (ring_scale_we) begin
      ring_scale <= ring_scale_wdata;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      addr            <= '0;
      total_intensity <= 48'd0;
      total_points    <= 32'd0;
      done            <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            height <= item.coord_height;
            inten  <= item.point_intensity;
            case (item.kind)
              pbd_pkg::KIND_ADD: begin
                is_add <= 1'b1;
                iter   <= 5'd0;
                if (total_points != 32'hFFFF_FFFF) begin
                  total_points    <= total_points + 32'd1;
                  total_intensity <= total_intensity + {32'd0, item.point_intensity};
                end
                if (x_in == '0 && y_in == '0) begin
                  acc    <= '0;
                  radius <= 32'd0;
                  state  <= ST_SEC;
                end else begin
                  state <= ST_ROT;
                  if (x_in < 0) begin
                    if (y_in >= 0) begin
                      x   <= y_in;
                      y   <= -x_in;
                      acc <= ACC_QTR;
                    end else begin
                      x   <= -y_in;
                      y   <= x_in;
                      acc <= -ACC_QTR;
                    end
                  end else begin
                    x   <= x_in;
                    y   <= y_in;
                    acc <= '0;
                  end
                end
              end
              pbd_pkg::KIND_READ: begin
                is_add <= 1'b0;
                if (32'(item.bin_index) >= 32'(NUM_BINS)) begin
                  result <= '0;
                  done   <= 1'b1;
                end else begin
                  addr  <= AW'(item.bin_index);
                  state <= ST_RD;
                end
              end
              pbd_pkg::KIND_CLEAR: begin
                addr            <= '0;
                total_intensity <= 48'd0;
                total_points    <= 32'd0;
                state           <= ST_CLEAR;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          if (addr == AW'(NUM_BINS - 1)) begin
            state <= ST_IDLE;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        // one CORDIC vectoring step per cycle
        ST_ROT: begin
          if (!y[XW-1]) begin
            x   <= x + dx;
            y   <= y - dy;
            acc <= acc + $signed({2'b00, pbd_pkg::atan_turn(iter)});
          end else begin
            x   <= x - dx;
            y   <= y + dy;
            acc <= acc - $signed({2'b00, pbd_pkg::atan_turn(iter)});
          end
          if (iter == 5'(pbd_pkg::CORDIC_STEPS - 1)) begin
            state <= ST_RAD;
          end
          iter <= iter + 5'd1;
        end
        ST_RAD: begin
          state <= ST_RADF;
        end
        // gain correction, radius as an integer (Q0)
        ST_RADF: begin
          radius <= 32'(rad_sum >> 38);
          state  <= ST_SEC;
        end
        ST_SEC: begin
          state <= ST_RING;
        end
        ST_RING: begin
          sector <= SW'(prod[63:32]);
          state  <= ST_IDX;
        end
        ST_IDX: begin
          if (prod[63:32] >= 32'(NUM_RINGS)) begin
            state <= ST_IDLE;
          end else begin
            addr  <= AW'(32'(sector) * 32'(NUM_RINGS) + prod[63:32]);
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= is_add ? ST_UPD : ST_RLAT;
        end
        ST_UPD: begin
          state <= ST_IDLE;
        end
        ST_RLAT: begin
          rec <= ram_rdata;
          if (ram_rdata.count == 16'd0) begin
            result <= '0;
            done   <= 1'b1;
            state  <= ST_IDLE;
          end else begin
            state <= ST_RM2;
          end
        end
        ST_RM2: begin
          lhs   <= prod;
          state <= ST_RM3;
        end
        ST_RM3: begin
          rhs_lo <= prod;
          state  <= ST_CMP;
        end
        // bin mean above global mean, by cross-multiplication
        ST_CMP: begin
          result.height_range  <= 24'(rec.high - rec.low);
          result.intensity_bit <= (lhs > (rhs_lo + {prod[31:0], 32'd0}));
          result.occupied      <= 1'b1;
          done                 <= 1'b1;
          state                <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/pbd_ram.sv -----
// Generic single write port RAM with one registered read port.
// No dependencies.
`default_nettype none
module pbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] wr_addr,
  input  wire [WIDTH-1:0]         wr_data,
  input  wire [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire
